@@ rtl/osm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_pkg: shared types and codes for the order statistic multiset.
// Holds operation codes, status codes, width and sign constants and the sequencer state type.
// ----------------------------------------------------------------------------
package osm_pkg;

  typedef enum logic [2:0] {
    FN_INSERT  = 3'd0,
    FN_REMOVE  = 3'd1,
    FN_RANK_LT = 3'd2,
    FN_RANK_LE = 3'd3,
    FN_COUNT   = 3'd4,
    FN_SELECT  = 3'd5,
    FN_CLEAR   = 3'd6,
    FN_NONE    = 3'd7
  } func_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned INDEX_W = 16;
  localparam logic [63:0] SIGN_FLIP = 64'h8000_0000_0000_0000;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

@@ rtl/osm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_ram: generic single-port RAM with registered read.
// One write and one read per cycle at a shared address; a write cycle reads the old data.
// ----------------------------------------------------------------------------
module osm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/order_statistic_multiset.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset: sorted multiset of signed 64-bit values.
// Distinct keys with counts sit in ascending slots of two RAMs; one
// sequencer scans, shifts and writes them one slot per step.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                 Contents
// s_axis    in   tvalid tready tdata     func, value, index
// m_axis    out  tvalid tready tdata     result_value, result_count, status
//
// An item's scan reads one slot at a time through the single RAM port and
// stops at the key, except for a select, which scans every used slot; every
// slot that an insert or a remove moves is read and then written back.
// Reset empties the set at once; count RAM entries at or above the used
// count are never used. Input is refused while an item or its result is
// pending; the result holds in its register until taken.
// ----------------------------------------------------------------------------
module order_statistic_multiset #(
  parameter int DISTINCT_ENTRIES = 256,
  parameter int COUNT_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: func[2:0], value[66:3], index[82:67], zero fill to 88 bits
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: result_value[63:0], result_count[79:64], status[81:80], zero fill
  output logic [87:0] m_axis_tdata
);
  import osm_pkg::*;

  localparam int AW = $clog2(DISTINCT_ENTRIES);
  localparam int UW = $clog2(DISTINCT_ENTRIES + 1);
  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  state_t state, state_next;

  // Item registers.
  func_t          func;
  logic [63:0]    key;
  logic [15:0]    idx;
  logic [UW-1:0]  used;
  logic [CW-1:0]  total;

  // Scan results.
  logic [UW-1:0]  pos;
  logic [CW-1:0]  acc;
  logic           hit;
  logic [CW-1:0]  hit_cnt;
  logic           sel_found;
  logic [63:0]    sel_key;
  logic [UW-1:0]  mv;
  logic           total_full_q;

  // RAM port.
  logic           we;
  logic [AW-1:0]  addr;
  logic [63:0]    k_wdata, k_rdata;
  logic [CW-1:0]  c_wdata, c_rdata;
  logic [63:0]    mk;
  logic [CW-1:0]  mc;

  // Output register.
  logic [63:0]    r_value;
  logic [15:0]    r_count;
  logic [1:0]     r_status;

  osm_ram #(.WIDTH(64), .DEPTH(DISTINCT_ENTRIES)) u_keys (
    .clk(clk), .we(we), .addr(addr), .wdata(k_wdata), .rdata(k_rdata));
  osm_ram #(.WIDTH(CW), .DEPTH(DISTINCT_ENTRIES)) u_cnts (
    .clk(clk), .we(we), .addr(addr), .wdata(c_wdata), .rdata(c_rdata));

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata  = {6'd0, r_status, r_count, r_value};

  logic insert_new, remove_gone;
  assign insert_new  = (func == FN_INSERT) && !hit;
  assign remove_gone = (func == FN_REMOVE) && hit && (hit_cnt == CW'(1));

  // Shared address, write data and next-state selection.
  always_comb begin
    we      = 1'b0;
    addr    = pos[AW-1:0];
    k_wdata = key;
    c_wdata = hit_cnt;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) state_next = S_SCAN_REQ;
      end
      S_SCAN_REQ: begin
        addr = pos[AW-1:0];
        state_next = (pos < used) ? S_SCAN : S_DECIDE;
      end
      S_SCAN: begin
        addr = pos[AW-1:0];
        state_next = (mk >= key && func != FN_SELECT) ? S_DECIDE : S_SCAN_REQ;
      end
      S_DECIDE: begin
        state_next = S_DONE;
        if (func == FN_INSERT && total != CNT_MAX &&
            (hit || used < UW'(DISTINCT_ENTRIES))) begin
          state_next = (insert_new && used > pos) ? S_SHIFT_RD : S_WRITE;
        end else if (func == FN_REMOVE && hit) begin
          state_next = (remove_gone && pos + UW'(1) < used) ? S_SHIFT_RD : S_WRITE;
        end
      end
      S_SHIFT_RD: begin
        // Insert moves slot mv-1 up; remove moves slot mv+1 down.
        addr = insert_new ? AW'(mv - UW'(1)) : AW'(mv + UW'(1));
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        addr = mv[AW-1:0];
        k_wdata = k_rdata;
        c_wdata = c_rdata;
        if (insert_new) state_next = (mv - UW'(1) > pos) ? S_SHIFT_RD : S_WRITE;
        else state_next = (mv + UW'(2) < used) ? S_SHIFT_RD : S_DONE;
      end
      S_WRITE: begin
        we = 1'b1;
        addr = pos[AW-1:0];
        if (func == FN_INSERT) c_wdata = hit ? hit_cnt + CW'(1) : CW'(1);
        else c_wdata = hit_cnt - CW'(1);
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Read data lands in the cycle after its address; mk/mc track the scanned slot.
  assign mk = k_rdata;
  assign mc = c_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      total <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            func <= func_t'(s_axis_tdata[2:0]);
            key  <= s_axis_tdata[66:3] ^ SIGN_FLIP;
            idx  <= s_axis_tdata[82:67];
            pos  <= '0;
            acc  <= '0;
            hit  <= 1'b0;
            hit_cnt <= '0;
            sel_found <= 1'b0;
            sel_key <= '0;
          end
        end
        S_SCAN: begin
          // Slot pos has been read; select tracks every slot, other functions stop at key.
          if (!sel_found && 33'(idx) < 33'(acc) + 33'(mc)) begin
            sel_found <= 1'b1;
            sel_key   <= mk;
          end
          if (mk < key) begin
            acc <= acc + mc;
            pos <= pos + UW'(1);
          end else begin
            if (mk == key) begin
              hit <= 1'b1;
              hit_cnt <= mc;
            end
            if (func != FN_SELECT) begin
              // Stop scanning: pos stays at first slot not below key.
              pos <= pos;
              used <= used;
            end else begin
              acc <= acc + mc;
              pos <= pos + UW'(1);
            end
          end
        end
        S_DECIDE: begin
          mv <= insert_new ? used : pos;
        end
        S_SHIFT_WR: begin
          mv <= insert_new ? mv - UW'(1) : mv + UW'(1);
        end
        S_WRITE: begin
          if (func == FN_INSERT) begin
            total <= total + CW'(1);
            if (!hit) used <= used + UW'(1);
          end
        end
        S_DONE: begin
          if (remove_gone) used <= used - UW'(1);
          m_axis_tvalid <= 1'b1;
          r_value  <= '0;
          r_count  <= '0;
          r_status <= ST_OK;
          case (func)
            FN_INSERT: begin
              if (total_full_q) r_status <= ST_FULL;
            end
            FN_REMOVE: begin
              if (!hit) r_status <= ST_NOT_FOUND;
              else total <= total - CW'(1);
            end
            FN_RANK_LT: r_count <= 16'(acc);
            FN_RANK_LE: r_count <= 16'(hit ? acc + hit_cnt : acc);
            FN_COUNT:   r_count <= 16'(hit_cnt);
            FN_SELECT: begin
              if (sel_found) r_value <= sel_key ^ SIGN_FLIP;
              else r_status <= ST_NOT_FOUND;
            end
            FN_CLEAR: begin
              used  <= '0;
              total <= '0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Insert refusal is decided from the state seen at the decision step.
  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      total_full_q <= (func == FN_INSERT) &&
                      (total == CNT_MAX || (!hit && used >= UW'(DISTINCT_ENTRIES)));
    end
  end

  // Assertions.
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(DISTINCT_ENTRIES)) else $error("used count out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> m_axis_tvalid) else $error("result lost");

endmodule

@@ sim/order_statistic_multiset_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset_check: scoreboard for the order statistic multiset.
// Watches both stream channels, predicts every result word from its own copy
// of the sorted multiset and compares the fields with what the block returns.
// ----------------------------------------------------------------------------
module order_statistic_multiset_check #(
  parameter int DISTINCT_ENTRIES = 256,
  parameter int COUNT_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // tdata: func[2:0], value[66:3], index[82:67], zero fill to 88 bits
  input  logic [87:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: result_value[63:0], result_count[79:64], status[81:80], zero fill
  input  logic [87:0] m_axis_tdata,
  output int          errors,
  output int          pending
);
  import osm_pkg::*;

  typedef struct packed {
    logic [63:0] found_value;
    logic [15:0] tally;
    logic [1:0]  status;
  } answer_t;

  localparam longint unsigned TOTAL_CAP = (64'd1 << COUNT_BITS) - 1;

  // Shadow multiset: keys biased so unsigned order matches signed order.
  logic [63:0]     held_key [DISTINCT_ENTRIES];
  longint unsigned held_cnt [DISTINCT_ENTRIES];
  int              held_used;
  longint unsigned held_total;
  answer_t         awaited_answers[$];

  function automatic longint unsigned count_before(int pos);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < pos && i < held_used; i++) s += held_cnt[i];
    return s;
  endfunction

  // Applies one operation word to the shadow multiset and returns its answer.
  function automatic answer_t apply_word(logic [87:0] w);
    answer_t         a;
    func_t           op;
    logic [63:0]     key;
    longint unsigned idx, acc, tally;
    int              p;
    logic            hit;
    op    = func_t'(w[2:0]);
    key   = w[66:3] ^ SIGN_FLIP;
    idx   = w[82:67];
    a     = '0;
    tally = 0;
    p     = 0;
    while (p < held_used && held_key[p] < key) p++;
    hit = (p < held_used) && (held_key[p] == key);
    case (op)
      FN_INSERT: begin
        if (held_total >= TOTAL_CAP) begin
          a.status = ST_FULL;
        end else if (hit) begin
          held_cnt[p]++;
          held_total++;
        end else if (held_used >= DISTINCT_ENTRIES) begin
          a.status = ST_FULL;
        end else begin
          for (int i = held_used; i > p; i--) begin
            held_key[i] = held_key[i-1];
            held_cnt[i] = held_cnt[i-1];
          end
          held_key[p] = key;
          held_cnt[p] = 1;
          held_used++;
          held_total++;
        end
      end
      FN_REMOVE: begin
        if (!hit) begin
          a.status = ST_NOT_FOUND;
        end else begin
          held_cnt[p]--;
          held_total--;
          if (held_cnt[p] == 0) begin
            for (int i = p; i + 1 < held_used; i++) begin
              held_key[i] = held_key[i+1];
              held_cnt[i] = held_cnt[i+1];
            end
            held_used--;
            held_cnt[held_used] = 0;
          end
        end
      end
      FN_RANK_LT: tally = count_before(p);
      FN_RANK_LE: tally = count_before(hit ? p + 1 : p);
      FN_COUNT:   tally = hit ? held_cnt[p] : 0;
      FN_SELECT: begin
        if (idx >= held_total) begin
          a.status = ST_NOT_FOUND;
        end else begin
          acc = 0;
          for (int i = 0; i < held_used; i++) begin
            acc += held_cnt[i];
            if (idx < acc) begin
              a.found_value = held_key[i] ^ SIGN_FLIP;
              break;
            end
          end
        end
      end
      FN_CLEAR: begin
        for (int i = 0; i < DISTINCT_ENTRIES; i++) held_cnt[i] = 0;
        held_used  = 0;
        held_total = 0;
      end
      default: ;
    endcase
    a.tally = tally[15:0];
    return a;
  endfunction

  // Prediction on accepted operation words, comparison on accepted results.
  always @(posedge clk) begin
    answer_t want, got;
    if (rst) begin
      for (int i = 0; i < DISTINCT_ENTRIES; i++) held_cnt[i] = 0;
      held_used  = 0;
      held_total = 0;
      errors     = 0;
      awaited_answers.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) awaited_answers.push_back(apply_word(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[63:0], m_axis_tdata[79:64], m_axis_tdata[81:80]};
        if (awaited_answers.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", got);
        end else begin
          want = awaited_answers.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: value %h/%h count %0d/%0d status %0d/%0d (expected/actual)",
                       want.found_value, got.found_value, want.tally, got.tally,
                       want.status, got.status);
          end
        end
      end
    end
    pending <= awaited_answers.size();
  end

endmodule

@@ sim/order_statistic_multiset_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset_test: top of the multiset testbench.
// Drives directed and random operation words with random gaps and result
// stalls, fills every distinct slot, and reports the verdict.
// ----------------------------------------------------------------------------
module order_statistic_multiset_test;
  import osm_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        calm = 1'b0;
  int          errors, pending, idle_cycles;
  logic [63:0] key_pool [24];

  order_statistic_multiset uut (.*);
  order_statistic_multiset_check checker_inst (.*);

  always #10 clk = ~clk;

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("order_statistic_multiset_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall before each word unless in a calm stretch.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Sends one operation word; entered and left at a falling edge.
  task automatic send_op(func_t op, logic [63:0] value, logic [15:0] index);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= {5'b0, index, value, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [63:0] v;
    logic [15:0] ix;
    int          pick;
    func_t       op;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corner cases on a small set.
    send_op(FN_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_op(FN_SELECT, 64'd0, 16'd0);
    send_op(FN_REMOVE, 64'd5, 16'd0);
    send_op(FN_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 16'd0);
    send_op(FN_INSERT, 64'h8000_0000_0000_0000, 16'd0);
    send_op(FN_INSERT, 64'd0, 16'd0);
    send_op(FN_INSERT, 64'd0, 16'd0);
    send_op(FN_RANK_LT, 64'd0, 16'd0);
    send_op(FN_RANK_LE, 64'd0, 16'd0);
    send_op(FN_RANK_LE, 64'h7FFF_FFFF_FFFF_FFFF, 16'd0);
    send_op(FN_RANK_LT, 64'h8000_0000_0000_0000, 16'd0);
    send_op(FN_COUNT, 64'd0, 16'd0);
    send_op(FN_SELECT, 64'd0, 16'd1);
    send_op(FN_SELECT, 64'd0, 16'd3);
    send_op(FN_SELECT, 64'd0, 16'd4);
    send_op(FN_SELECT, 64'd0, 16'hFFFF);
    send_op(FN_REMOVE, 64'd0, 16'd0);
    send_op(FN_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF, 16'd0);
    send_op(FN_CLEAR, 64'd0, 16'd0);
    send_op(FN_COUNT, 64'h8000_0000_0000_0000, 16'd0);

    // Fill every distinct slot in ascending order, then probe the full set.
    calm = 1'b1;
    for (int i = 0; i < 256; i++) send_op(FN_INSERT, 64'(i * 7 - 900), 16'd0);
    calm = 1'b0;
    send_op(FN_INSERT, 64'd123456, 16'd0);
    send_op(FN_INSERT, 64'(-900), 16'd0);
    send_op(FN_RANK_LE, 64'h7FFF_FFFF_FFFF_FFFF, 16'd0);
    send_op(FN_SELECT, 64'd0, 16'd256);
    send_op(FN_SELECT, 64'd0, 16'd257);
    send_op(FN_CLEAR, 64'd0, 16'd0);

    // Random mix over a small key pool so that hits are common.
    key_pool[0] = 64'h8000_0000_0000_0000;
    key_pool[1] = 64'h7FFF_FFFF_FFFF_FFFF;
    key_pool[2] = 64'd0;
    key_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;
    for (int i = 4; i < 24; i++) key_pool[i] = {$urandom, $urandom};
    for (int n = 0; n < 400; n++) begin
      calm = ((n / 100) % 3) == 2;
      if (n == 200) drain();
      pick = $urandom_range(0, 99);
      if (pick < 32)      op = FN_INSERT;
      else if (pick < 52) op = FN_REMOVE;
      else if (pick < 60) op = FN_RANK_LT;
      else if (pick < 68) op = FN_RANK_LE;
      else if (pick < 76) op = FN_COUNT;
      else if (pick < 95) op = FN_SELECT;
      else if (pick < 96) op = FN_CLEAR;
      else                op = FN_NONE;
      v  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                       : key_pool[$urandom_range(0, 23)];
      ix = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      send_op(op, v, ix);
    end
    calm = 1'b0;

    // Wait for every result, then a short settle.
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("order_statistic_multiset_test OK");
    end else begin
      $display("order_statistic_multiset_test NOT OK");
    end
    $finish;
  end

endmodule
